@@ rtl/pce_pkg.sv @@
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types and constants for the correlation engine: arithmetic unit
// commands, sequencer states, mode, register and status codes.
// ----------------------------------------------------------------------------
package pce_pkg;

	localparam int COEF_W   = 32;
	localparam int STATUS_W = 2;
	localparam int PAIRS_W  = 13;
	localparam int MODE_W   = 2;
	localparam int LAG_W    = 8;
	localparam int CFG_W    = 8;
	localparam int STEP_W   = 8;

	localparam logic [MODE_W-1:0] MODE_CORR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RSQ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AUTO = 2'd2;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_LAG  = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_ZVAR = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FEW  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_OVF  = 2'd3;

	typedef enum logic [1:0] {
		ALU_MAC,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic              neg;
		logic [STEP_W-1:0] steps;
	} alu_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_VX0,
		ST_VX1,
		ST_VY0,
		ST_VY1,
		ST_CV0,
		ST_CV1,
		ST_VAR,
		ST_COV2,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} state_t;

endpackage

@@ rtl/pce_accum.sv @@
// ----------------------------------------------------------------------------
// pce_accum
// Per-word pairing, lag delay line and running sums. Each accepted word steps
// through the phase counter; a single signed multiplier forms xx, yy and xy.
// ----------------------------------------------------------------------------
module pce_accum #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_SAMPLES = 4096,
	parameter int MAX_LAG     = 256,
	parameter int CW          = 13,
	parameter int SW1         = 29,
	parameter int SW2         = 44
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          clear,
	input  logic signed [SAMPLE_BITS-1:0] x_in,
	input  logic signed [SAMPLE_BITS-1:0] y_in,
	input  logic [pce_pkg::MODE_W-1:0]    mode,
	input  logic [pce_pkg::LAG_W-1:0]     lag,
	output logic                          done,
	output logic signed [SW1-1:0]         sum_x,
	output logic signed [SW1-1:0]         sum_y,
	output logic signed [SW2-1:0]         sum_xx,
	output logic signed [SW2-1:0]         sum_yy,
	output logic signed [SW2-1:0]         sum_xy,
	output logic [CW-1:0]                 pair_count,
	output logic                          overflow
);
	import pce_pkg::*;

	localparam int LW  = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
	localparam int VLW = $clog2(MAX_LAG + 1);
	localparam int LGW = ((LW > LAG_W) ? LW : LAG_W) + 1;

	logic signed [SAMPLE_BITS-1:0] lag_mem [MAX_LAG];
	logic signed [SAMPLE_BITS-1:0] rd_q, x_q, y_q, a_q, b_q;
	logic                          pair_q, line_q, auto_q, done_q;
	logic [2:0]                    ph_q;
	logic [CW-1:0]                 sample_count_q, pair_count_q;
	logic [LW-1:0]                 wp_q;
	logic [VLW-1:0]                valid_q;
	logic signed [SW1-1:0]         sum_x_q, sum_y_q;
	logic signed [SW2-1:0]         sum_xx_q, sum_yy_q, sum_xy_q;
	logic                          overflow_q;

	logic                              keep, is_auto, lag_ok, have, pair_d;
	logic [LGW-1:0]                    lag_x, wp_x, raddr_x;
	logic [LW-1:0]                     raddr;
	logic signed [SAMPLE_BITS-1:0]     m1, m2;
	logic signed [2*SAMPLE_BITS-1:0]   prod;

	always_comb begin
		keep    = sample_count_q < CW'(MAX_SAMPLES);
		is_auto = mode == MODE_AUTO;
		lag_x   = LGW'(lag);
		wp_x    = LGW'(wp_q);
		lag_ok  = lag_x <= LGW'(MAX_LAG - 1);
		have    = LGW'(valid_q) >= lag_x;
		raddr_x = (wp_x >= lag_x) ? wp_x - lag_x : wp_x + LGW'(MAX_LAG) - lag_x;
		raddr   = raddr_x[LW-1:0];
		pair_d  = keep && (!is_auto || lag == '0 || (lag_ok && have));
		m1      = (ph_q == 3'd3) ? b_q : a_q;
		m2      = (ph_q == 3'd2) ? a_q : b_q;
		prod    = m1 * m2;
	end

	// delay line: read the lagged entry, then push the new sample
	always_ff @(posedge clk) begin
		if (start) begin
			rd_q <= lag_mem[raddr];
			if (keep && is_auto) begin
				lag_mem[wp_q] <= x_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_in;
			y_q <= y_in;
		end
		if (ph_q == 3'd1) begin
			a_q <= line_q ? rd_q : x_q;
			b_q <= auto_q ? x_q : y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q           <= '0;
			done_q         <= 1'b0;
			pair_q         <= 1'b0;
			line_q         <= 1'b0;
			auto_q         <= 1'b0;
			sample_count_q <= '0;
			pair_count_q   <= '0;
			wp_q           <= '0;
			valid_q        <= '0;
			overflow_q     <= 1'b0;
			sum_x_q        <= '0;
			sum_y_q        <= '0;
			sum_xx_q       <= '0;
			sum_yy_q       <= '0;
			sum_xy_q       <= '0;
		end else begin
			done_q <= ph_q == 3'd4;
			if (clear) begin
				sample_count_q <= '0;
				pair_count_q   <= '0;
				wp_q           <= '0;
				valid_q        <= '0;
				overflow_q     <= 1'b0;
				sum_x_q        <= '0;
				sum_y_q        <= '0;
				sum_xx_q       <= '0;
				sum_yy_q       <= '0;
				sum_xy_q       <= '0;
			end else if (start) begin
				ph_q   <= 3'd1;
				pair_q <= pair_d;
				line_q <= keep && is_auto && lag != '0;
				auto_q <= is_auto;
				if (!keep) begin
					overflow_q <= 1'b1;
				end else begin
					sample_count_q <= sample_count_q + 1'b1;
					if (is_auto) begin
						wp_q <= (wp_x == LGW'(MAX_LAG - 1)) ? '0 : wp_q + 1'b1;
						if (LGW'(valid_q) < LGW'(MAX_LAG)) begin
							valid_q <= valid_q + 1'b1;
						end
					end
				end
			end else if (ph_q != '0) begin
				ph_q <= (ph_q == 3'd4) ? '0 : ph_q + 1'b1;
				if (pair_q) begin
					unique case (ph_q)
						3'd2: begin
							sum_x_q  <= sum_x_q + SW1'(a_q);
							sum_y_q  <= sum_y_q + SW1'(b_q);
							sum_xx_q <= sum_xx_q + SW2'(prod);
						end
						3'd3: begin
							sum_yy_q <= sum_yy_q + SW2'(prod);
						end
						3'd4: begin
							sum_xy_q     <= sum_xy_q + SW2'(prod);
							pair_count_q <= pair_count_q + 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	assign done       = done_q;
	assign sum_x      = sum_x_q;
	assign sum_y      = sum_y_q;
	assign sum_xx     = sum_xx_q;
	assign sum_yy     = sum_yy_q;
	assign sum_xy     = sum_xy_q;
	assign pair_count = pair_count_q;
	assign overflow   = overflow_q;

endmodule

@@ rtl/pce_alu.sv @@
// ----------------------------------------------------------------------------
// pce_alu
// Shared iterative unit around one wide adder: shift-add multiply-accumulate,
// restoring divide with fractional quotient, and bitwise integer square root.
// ----------------------------------------------------------------------------
module pce_alu #(
	parameter int AW = 118
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pce_pkg::alu_cmd_t      cmd,
	input  logic signed [AW-1:0]   opa,
	input  logic signed [AW-1:0]   opb,
	input  logic signed [AW-1:0]   opc,
	output logic                   done,
	output logic [AW-1:0]          result
);
	import pce_pkg::*;

	logic [AW-1:0]     r0_q, r1_q, r2_q;
	logic [STEP_W-1:0] cnt_q;
	alu_op_t           op_q;
	logic              sub_q, busy_q, done_q;

	logic [AW-1:0] lhs, rhs;
	logic          inv, ge;
	logic [AW:0]   sum;

	always_comb begin
		lhs = r0_q;
		rhs = r1_q;
		inv = 1'b1;
		unique case (op_q)
			ALU_MAC: begin
				rhs = r2_q[0] ? r1_q : '0;
				inv = sub_q;
			end
			ALU_DIV: begin
				rhs = r1_q;
			end
			ALU_SQRT: begin
				rhs = r2_q | r1_q;
			end
			default: begin
			end
		endcase
		sum = {1'b0, lhs} + {1'b0, inv ? ~rhs : rhs} + (AW+1)'(inv);
		ge  = sum[AW];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			r0_q <= opc;
			r1_q <= opa;
			if (cmd.op == ALU_MAC) begin
				r2_q <= opb[AW-1] ? -opb : opb;
			end else begin
				r2_q <= '0;
			end
			sub_q <= cmd.neg ^ opb[AW-1];
		end else if (busy_q) begin
			unique case (op_q)
				ALU_MAC: begin
					r0_q <= sum[AW-1:0];
					r1_q <= r1_q << 1;
					r2_q <= r2_q >> 1;
				end
				ALU_DIV: begin
					r0_q <= (ge ? sum[AW-1:0] : r0_q) << 1;
					r2_q <= {r2_q[AW-2:0], ge};
				end
				ALU_SQRT: begin
					if (ge) begin
						r0_q <= sum[AW-1:0];
						r2_q <= (r2_q >> 1) | r1_q;
					end else begin
						r2_q <= r2_q >> 1;
					end
					r1_q <= r1_q >> 2;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= ALU_MAC;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				op_q   <= cmd.op;
				cnt_q  <= cmd.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = (op_q == ALU_MAC) ? r0_q : r2_q;

endmodule

@@ rtl/pearson_correlation_engine_unit.sv @@
// ----------------------------------------------------------------------------
// pearson_correlation_engine_unit
// Running-sum Pearson correlation with r, r squared and autocorrelation modes.
//
//   channel  direction  handshake               word
//   in       sink       in_valid / in_stall     x_sample, y_sample, last
//   out      source     out_valid / out_stall   coefficient, status, pairs_used
//   cfg      sink       cfg_we                  cfg_index, cfg_data
//
// A word without last runs from accept through the accumulate phases on the
// sample multiplier and back to idle. After a word with last and two or more
// pairs the shared unit runs eight multiply-accumulates of 2*SW1 steps, a divide of
// 2*FRAC_BITS+1 steps (FRAC_BITS+1 in r-squared mode) and, outside r-squared
// mode, a square root of FRAC_BITS+1 steps; a zero variance stops it earlier.
// in_stall is high from acceptance until idle again, through the result word.
// Reset clears the sums, counts and the mode and lag registers (lag to 1).
// ----------------------------------------------------------------------------
module pearson_correlation_engine_unit #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_SAMPLES = 4096,
	parameter int MAX_LAG     = 256,
	parameter int FRAC_BITS   = 30
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       x_sample,
	input  logic signed [SAMPLE_BITS-1:0]       y_sample,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pce_pkg::COEF_W-1:0]   coefficient,
	output logic [pce_pkg::STATUS_W-1:0]        status,
	output logic [pce_pkg::PAIRS_W-1:0]         pairs_used,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [pce_pkg::CFG_W-1:0]           cfg_data
);
	import pce_pkg::*;

	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int SW1 = SAMPLE_BITS + CW;
	localparam int SW2 = 2 * SAMPLE_BITS + CW;
	localparam int VW  = 2 * SW1;
	localparam int AW  = 2 * VW + 2;

	state_t state_q, state_d;
	logic   go_q;

	logic [MODE_W-1:0] mode_q;
	logic [LAG_W-1:0]  lag_q;
	logic              sq_q, last_q;
	logic [AW-1:0]     vx_q, vy_q, cov_q, d_q;
	logic              cov_neg_q;
	logic [COEF_W-1:0] coef_q;
	logic [STATUS_W-1:0] status_q;

	logic                  accept, acc_done, acc_clear, overflow;
	logic signed [SW1-1:0] sum_x, sum_y;
	logic signed [SW2-1:0] sum_xx, sum_yy, sum_xy;
	logic [CW-1:0]         pair_count;

	alu_cmd_t            cmd;
	logic signed [AW-1:0] opa, opb, opc;
	logic                alu_done;
	logic [AW-1:0]       alu_res;
	logic                zero_var;
	logic [COEF_W-1:0]   q;

	assign accept   = in_valid && !in_stall;
	assign zero_var = (vx_q == '0) || (alu_res == '0);
	assign q        = alu_res[COEF_W-1:0];

	pce_accum #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_SAMPLES(MAX_SAMPLES),
		.MAX_LAG    (MAX_LAG),
		.CW         (CW),
		.SW1        (SW1),
		.SW2        (SW2)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.clear     (acc_clear),
		.x_in      (x_sample),
		.y_in      (y_sample),
		.mode      (mode_q),
		.lag       (lag_q),
		.done      (acc_done),
		.sum_x     (sum_x),
		.sum_y     (sum_y),
		.sum_xx    (sum_xx),
		.sum_yy    (sum_yy),
		.sum_xy    (sum_xy),
		.pair_count(pair_count),
		.overflow  (overflow)
	);

	pce_alu #(
		.AW(AW)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.opa   (opa),
		.opb   (opb),
		.opc   (opc),
		.done  (alu_done),
		.result(alu_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_ACC;
			ST_ACC: begin
				if (acc_done) begin
					if (!last_q) state_d = ST_IDLE;
					else if (pair_count < CW'(2)) state_d = ST_OUT;
					else state_d = ST_VX0;
				end
			end
			ST_VX0:  if (alu_done) state_d = ST_VX1;
			ST_VX1:  if (alu_done) state_d = ST_VY0;
			ST_VY0:  if (alu_done) state_d = ST_VY1;
			ST_VY1:  if (alu_done) state_d = zero_var ? ST_OUT : ST_CV0;
			ST_CV0:  if (alu_done) state_d = ST_CV1;
			ST_CV1:  if (alu_done) state_d = ST_VAR;
			ST_VAR:  if (alu_done) state_d = ST_COV2;
			ST_COV2: if (alu_done) state_d = ST_DIV;
			ST_DIV:  if (alu_done) state_d = sq_q ? ST_OUT : ST_SQRT;
			ST_SQRT: if (alu_done) state_d = ST_OUT;
			ST_OUT:  if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and shared-unit operands
	always_comb begin
		in_stall  = state_q != ST_IDLE;
		out_valid = state_q == ST_OUT;
		acc_clear = (state_q == ST_OUT) && !out_stall;
		cmd.start = go_q && state_q != ST_IDLE && state_q != ST_ACC && state_q != ST_OUT;
		cmd.op    = ALU_MAC;
		cmd.neg   = 1'b0;
		cmd.steps = STEP_W'(VW);
		opa       = '0;
		opb       = '0;
		opc       = '0;
		unique case (state_q)
			ST_VX0: begin
				opa = AW'(sum_xx);
				opb = AW'(pair_count);
			end
			ST_VX1: begin
				opc     = alu_res;
				opa     = AW'(sum_x);
				opb     = AW'(sum_x);
				cmd.neg = 1'b1;
			end
			ST_VY0: begin
				opa = AW'(sum_yy);
				opb = AW'(pair_count);
			end
			ST_VY1: begin
				opc     = alu_res;
				opa     = AW'(sum_y);
				opb     = AW'(sum_y);
				cmd.neg = 1'b1;
			end
			ST_CV0: begin
				opa = AW'(sum_xy);
				opb = AW'(pair_count);
			end
			ST_CV1: begin
				opc     = alu_res;
				opa     = AW'(sum_x);
				opb     = AW'(sum_y);
				cmd.neg = 1'b1;
			end
			ST_VAR: begin
				opa = vx_q;
				opb = vy_q;
			end
			ST_COV2: begin
				opa = cov_q;
				opb = cov_q;
			end
			ST_DIV: begin
				cmd.op    = ALU_DIV;
				cmd.steps = sq_q ? STEP_W'(FRAC_BITS + 1) : STEP_W'(2 * FRAC_BITS + 1);
				opc       = alu_res;
				opa       = d_q;
			end
			ST_SQRT: begin
				cmd.op    = ALU_SQRT;
				cmd.steps = STEP_W'(FRAC_BITS + 1);
				opc       = alu_res;
				opa       = AW'(1) << (2 * FRAC_BITS);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q    <= 1'b0;
			mode_q  <= MODE_CORR;
			lag_q   <= LAG_W'(1);
			sq_q    <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= state_d != state_q;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE: mode_q <= cfg_data[MODE_W-1:0];
					REG_LAG:  lag_q  <= cfg_data[LAG_W-1:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				sq_q   <= mode_q == MODE_RSQ;
				last_q <= last;
			end
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		if (alu_done) begin
			unique case (state_q)
				ST_VX1: vx_q <= alu_res;
				ST_VY1: vy_q <= alu_res;
				ST_CV1: begin
					cov_q     <= alu_res;
					cov_neg_q <= alu_res[AW-1];
				end
				ST_VAR: d_q <= alu_res;
				ST_DIV: coef_q <= q;
				ST_SQRT: coef_q <= cov_neg_q ? -q : q;
				default: begin
				end
			endcase
		end
		if (state_q != ST_OUT && state_d == ST_OUT) begin
			if (state_q == ST_ACC) begin
				status_q <= STAT_FEW;
				coef_q   <= '0;
			end else if (state_q == ST_VY1) begin
				status_q <= STAT_ZVAR;
				coef_q   <= '0;
			end else begin
				status_q <= overflow ? STAT_OVF : STAT_OK;
			end
		end
	end

	assign coefficient = coef_q;
	assign status      = status_q;
	assign pairs_used  = PAIRS_W'(pair_count);

endmodule

@@ rtl/pce_checker.sv @@
// ----------------------------------------------------------------------------
// pce_checker
// Port-level checks on the correlation engine result channel.
// ----------------------------------------------------------------------------
module pce_checker #(
	parameter int FRAC_BITS = 30
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [pce_pkg::COEF_W-1:0] coefficient,
	input logic [pce_pkg::STATUS_W-1:0]      status,
	input logic [pce_pkg::PAIRS_W-1:0]       pairs_used
);
	import pce_pkg::*;

	localparam logic signed [COEF_W-1:0] UNITY = COEF_W'(1) << FRAC_BITS;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(coefficient)
			&& $stable(status) && $stable(pairs_used))
		else $error("result word changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_FEW || status == STAT_ZVAR) |-> coefficient == '0)
		else $error("nonzero coefficient with error status");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> coefficient <= UNITY && coefficient >= -UNITY)
		else $error("coefficient magnitude above one");

endmodule

bind pearson_correlation_engine_unit pce_checker #(.FRAC_BITS(FRAC_BITS)) u_pce_checker (.*);
